// File: rtl/core/htw_pkg.sv
// Shared types, codes and default sizes for the hierarchical timer wheel.
// Used by every module in rtl/core; depends on nothing.
`timescale 1ns / 1ps

package htw_pkg;

    localparam int SLOT_BITS_DEF   = 6;
    localparam int WHEEL_COUNT_DEF = 4;
    localparam int POOL_SIZE_DEF   = 64;
    localparam int TICK_MS_DEF     = 50;

    localparam int          LINK_W  = 7;
    localparam int          COUNT_W = 7;
    localparam logic [6:0]  NIL     = 7'h7F;

    typedef enum logic [1:0] {
        OP_ADD        = 2'd0,
        OP_CANCEL     = 2'd1,
        OP_CANCEL_ALL = 2'd2,
        OP_TICK       = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_ADD        = 3'd0,
        KIND_CANCEL     = 3'd1,
        KIND_CANCEL_ALL = 3'd2,
        KIND_FIRED      = 3'd3,
        KIND_TICK_DONE  = 3'd4
    } t_kind;

    // One slot list: head and tail entry, NIL when empty.
    typedef struct packed {
        logic [LINK_W-1:0] first;
        logic [LINK_W-1:0] tail;
    } t_slot;

    // Stored timer fields kept in the entry memory.
    typedef struct packed {
        logic [31:0] due;
        logic [31:0] period;
        logic [31:0] ident;
        logic        repeat_en;
    } t_entry;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

    // Fired id written into the result buffer during a tick.
    typedef struct packed {
        logic        push;
        logic [31:0] id;
    } t_push;

    // Hand-off of a finished item to the result stage.
    typedef struct packed {
        logic               req;
        t_kind              kind;
        logic [31:0]        id;
        logic               ok;
        logic [COUNT_W-1:0] held;
    } t_drain;

endpackage

// File: rtl/core/hierarchical_timer_wheel_core.sv
// Top level of the hierarchical timer wheel: sequencer, divider, result stage.
// Depends on htw_pkg, htw_div, htw_out and htw_seq.
`timescale 1ns / 1ps

//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------
//  command   | start, busy (taken when    | i_op, i_periodic, i_period_ms,
//            |  start high and busy low)  |  i_delay_ms, i_cancel_id
//  result    | o_valid, one cycle a beat  | o_kind, o_timer_id, o_ok,
//            |                            |  o_live_count, o_last
//
//  After reset the block sweeps every slot list to empty, one list a cycle
//  (WHEEL_COUNT * 2^SLOT_BITS lists, 256 at the defaults), with busy high.
//  How long a command takes is set by the sequencer and its single memory ports:
//  add runs two reciprocal-multiply divisions by TICK_MS and, unless the
//  range checks reject it, scans the occupied pool entries ahead of the
//  free one; cancel scans pool entries until a match, cancel-all does no
//  scan, and a tick visits lists and walks their timers, then sends
//  one beat per fired timer. The receiver cannot stall results.

module hierarchical_timer_wheel_core #(
    parameter int SLOT_BITS   = htw_pkg::SLOT_BITS_DEF,
    parameter int WHEEL_COUNT = htw_pkg::WHEEL_COUNT_DEF,
    parameter int POOL_SIZE   = htw_pkg::POOL_SIZE_DEF,
    parameter int TICK_MS     = htw_pkg::TICK_MS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_op,
    input  logic                        i_periodic,
    input  logic [31:0]                 i_period_ms,
    input  logic [31:0]                 i_delay_ms,
    input  logic [31:0]                 i_cancel_id,
    output logic                        o_valid,
    output logic [2:0]                  o_kind,
    output logic [31:0]                 o_timer_id,
    output logic                        o_ok,
    output logic [htw_pkg::COUNT_W-1:0] o_live_count,
    output logic                        o_last
);

    htw_pkg::t_div_req div_req;
    htw_pkg::t_div_rsp div_rsp;
    htw_pkg::t_push    push;
    htw_pkg::t_drain   drain;
    logic              seq_busy;
    logic              out_busy;
    logic              accept;

    // Take a command only when both the sequencer and the result stage are free.
    assign busy   = seq_busy | out_busy;
    assign accept = start & ~busy;

    htw_seq #(
        .SLOT_BITS   (SLOT_BITS),
        .WHEEL_COUNT (WHEEL_COUNT),
        .POOL_SIZE   (POOL_SIZE),
        .TICK_MS     (TICK_MS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_op        (i_op),
        .i_periodic  (i_periodic),
        .i_period_ms (i_period_ms),
        .i_delay_ms  (i_delay_ms),
        .i_cancel_id (i_cancel_id),
        .i_div_rsp   (div_rsp),
        .o_div_req   (div_req),
        .o_push      (push),
        .o_drain     (drain),
        .o_busy      (seq_busy)
    );

    htw_div #(
        .TICK_MS (TICK_MS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Hold fired ids until the tick finishes so every beat carries the final count.
    htw_out #(
        .POOL_SIZE (POOL_SIZE)
    ) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_drain      (drain),
        .o_busy       (out_busy),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_timer_id   (o_timer_id),
        .o_ok         (o_ok),
        .o_live_count (o_live_count),
        .o_last       (o_last)
    );

endmodule

// File: rtl/core/htw_div.sv
// Divider by the tick length: reciprocal multiply, registering the numerator, the product and the quotient in turn.
// Depends on htw_pkg for the request and response structs.
`timescale 1ns / 1ps

module htw_div #(
    parameter int TICK_MS = htw_pkg::TICK_MS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htw_pkg::t_div_req i_req,
    output htw_pkg::t_div_rsp o_rsp
);

    // Rounded-up reciprocal, exact for every 32-bit numerator.
    localparam int          SHIFT = 32 + $clog2(TICK_MS);
    localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(TICK_MS) - 64'd1)
                                    / 64'(TICK_MS);

    logic        r_stage1;
    logic        r_stage2;
    logic        r_done;
    logic [31:0] r_num;
    logic [63:0] r_prod;
    logic [31:0] r_quot;
    logic [64:0] prod_sum;

    // Bit 32 of the reciprocal adds the numerator shifted up by 32.
    assign prod_sum = {1'b0, r_prod} + (RECIP[32] ? {1'b0, r_num, 32'd0} : 65'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage1 <= 1'b0;
            r_stage2 <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_stage1 <= i_req.start;
            r_stage2 <= r_stage1;
            r_done   <= r_stage2;
            if (i_req.start) begin
                r_num <= i_req.num;
            end
            if (r_stage1) begin
                r_prod <= 64'(r_num) * 64'(RECIP[31:0]);
            end
            if (r_stage2) begin
                r_quot <= 32'(prod_sum >> SHIFT);
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// File: rtl/core/htw_out.sv
// Result stage: buffers fired ids of a tick and sends every result beat.
// Depends on htw_pkg for kinds and the push and drain structs.
`timescale 1ns / 1ps

module htw_out #(
    parameter int POOL_SIZE = htw_pkg::POOL_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  htw_pkg::t_push               i_push,
    input  htw_pkg::t_drain              i_drain,
    output logic                         o_busy,
    output logic                         o_valid,
    output logic [2:0]                   o_kind,
    output logic [31:0]                  o_timer_id,
    output logic                         o_ok,
    output logic [htw_pkg::COUNT_W-1:0]  o_live_count,
    output logic                         o_last
);

    localparam int IW = $clog2(POOL_SIZE);
    localparam int CW = $clog2(POOL_SIZE + 1);

    logic [31:0]                  fifo_mem [POOL_SIZE];
    logic [CW-1:0]                r_wptr;
    logic [IW-1:0]                r_rptr;
    logic                         r_stream;
    logic                         r_valid;
    logic                         r_last;
    logic                         r_use_q;
    logic [31:0]                  r_q;
    logic [31:0]                  r_id;
    logic                         r_ok;
    htw_pkg::t_kind               r_kind;
    logic [htw_pkg::COUNT_W-1:0]  r_held;
    logic                         end_beat;

    assign end_beat = (CW'(r_rptr) + CW'(1)) == r_wptr;

    always_ff @(posedge i_clk) begin
        if (i_push.push && r_wptr < CW'(POOL_SIZE)) begin
            fifo_mem[r_wptr[IW-1:0]] <= i_push.id;
        end
        r_q <= fifo_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_stream <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_push.push && r_wptr < CW'(POOL_SIZE)) begin
                r_wptr <= r_wptr + CW'(1);
            end
            if (i_drain.req) begin
                r_held <= i_drain.held;
                if (i_drain.kind == htw_pkg::KIND_TICK_DONE && r_wptr != '0) begin
                    r_stream <= 1'b1;
                    r_rptr   <= '0;
                end else begin
                    r_valid <= 1'b1;
                    r_last  <= 1'b1;
                    r_use_q <= 1'b0;
                    r_kind  <= i_drain.kind;
                    r_id    <= i_drain.id;
                    r_ok    <= i_drain.ok;
                end
            end else if (r_stream) begin
                // one fired id per beat, read data lands with the strobe
                r_valid <= 1'b1;
                r_use_q <= 1'b1;
                r_kind  <= htw_pkg::KIND_FIRED;
                r_ok    <= 1'b1;
                r_last  <= end_beat;
                r_rptr  <= r_rptr + IW'(1);
                if (end_beat) begin
                    r_stream <= 1'b0;
                    r_wptr   <= '0;
                end
            end
        end
    end

    assign o_busy       = r_stream;
    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_timer_id   = r_use_q ? r_q : r_id;
    assign o_ok         = r_ok;
    assign o_live_count = r_held;
    assign o_last       = r_last;

endmodule

// File: rtl/core/htw_seq.sv
// Sequencer of the timer wheel: slot, link and entry memories, pool flags,
// add/cancel/tick control. Depends on htw_pkg; drives htw_div and htw_out.
`timescale 1ns / 1ps

module htw_seq #(
    parameter int SLOT_BITS   = htw_pkg::SLOT_BITS_DEF,
    parameter int WHEEL_COUNT = htw_pkg::WHEEL_COUNT_DEF,
    parameter int POOL_SIZE   = htw_pkg::POOL_SIZE_DEF,
    parameter int TICK_MS     = htw_pkg::TICK_MS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_op,
    input  logic              i_periodic,
    input  logic [31:0]       i_period_ms,
    input  logic [31:0]       i_delay_ms,
    input  logic [31:0]       i_cancel_id,
    input  htw_pkg::t_div_rsp i_div_rsp,
    output htw_pkg::t_div_req o_div_req,
    output htw_pkg::t_push    o_push,
    output htw_pkg::t_drain   o_drain,
    output logic              o_busy
);

    localparam int SB         = SLOT_BITS;
    localparam int WC         = WHEEL_COUNT;
    localparam int WB         = $clog2(WC);
    localparam int LW         = WB + SB;
    localparam int LIST_COUNT = WC * (1 << SB);
    localparam int IW         = $clog2(POOL_SIZE);
    localparam int CW         = $clog2(POOL_SIZE + 1);
    localparam int LVW        = $clog2(WC + 1);
    localparam int SPAN_BITS  = SB * WC;
    localparam int KW         = htw_pkg::COUNT_W;

    typedef enum logic [16:0] {
        S_CLEAR  = 17'h00001,
        S_IDLE   = 17'h00002,
        S_DIV    = 17'h00004,
        S_ACHK   = 17'h00008,
        S_AFREE  = 17'h00010,
        S_AWRITE = 17'h00020,
        S_CRD    = 17'h00040,
        S_CCK    = 17'h00080,
        S_TLVL   = 17'h00100,
        S_WHEAD  = 17'h00200,
        S_WHEAD2 = 17'h00400,
        S_WLOOP  = 17'h00800,
        S_WDATA  = 17'h01000,
        S_PL0    = 17'h02000,
        S_PL1    = 17'h04000,
        S_TEND   = 17'h08000,
        S_DONE   = 17'h10000
    } t_state;

    htw_pkg::t_slot  slot_mem  [LIST_COUNT];
    logic [6:0]      link_mem  [POOL_SIZE];
    htw_pkg::t_entry entry_mem [POOL_SIZE];

    t_state          r_state;
    t_state          r_ret;
    logic [LW-1:0]   r_clr;
    logic [31:0]     r_tick;
    logic [31:0]     r_next_id;
    logic [KW-1:0]   r_held;
    logic [POOL_SIZE-1:0] r_used;
    logic [POOL_SIZE-1:0] r_canc;

    logic            r_periodic;
    logic [31:0]     r_period_ms;
    logic [31:0]     r_cid;
    logic            r_divsel;
    logic [31:0]     r_dl;
    logic [31:0]     r_iv;
    logic [IW-1:0]   r_idx;
    logic [LVW-1:0]  r_lvl;
    logic            r_prev_zero;
    logic            r_fire;
    logic [LW-1:0]   r_list;
    logic [LW-1:0]   r_plist;
    logic [6:0]      r_cur;
    logic [CW-1:0]   r_n;
    logic [IW-1:0]   r_pidx;
    logic [31:0]     r_pdue;

    htw_pkg::t_kind  r_kind;
    logic [31:0]     r_id;
    logic            r_ok;

    htw_pkg::t_slot  r_slot_q;
    logic [6:0]      r_link_q;
    htw_pkg::t_entry r_ent_q;

    // memory ports
    logic            slot_we;
    logic [LW-1:0]   slot_waddr;
    htw_pkg::t_slot  slot_wdata;
    logic [LW-1:0]   slot_raddr;
    logic            link_we;
    logic [IW-1:0]   link_waddr;
    logic [6:0]      link_wdata;
    logic            ent_we;
    logic [IW-1:0]   ent_waddr;
    htw_pkg::t_entry ent_wdata;
    logic [IW-1:0]   ent_raddr;

    logic [IW-1:0]   ci;
    logic [31:0]     ticks;
    logic [WB-1:0]   pl_w;
    logic [SB-1:0]   pl_s;
    logic [LW-1:0]   plist;
    logic [SB-1:0]   lvl_digit;
    logic            add_bad;
    logic            slot_empty;

    assign ci = r_cur[IW-1:0];
    assign slot_empty = r_slot_q.tail >= 7'(POOL_SIZE);

    // Wheel choice: lowest wheel whose range covers the remaining ticks.
    always_comb begin
        ticks = r_pdue - r_tick;
        pl_w  = '0;
        pl_s  = '0;
        for (int i = WC - 1; i >= 0; i--) begin
            if ((ticks >> (SB * (i + 1))) == 32'd0) begin
                pl_w = WB'(i);
                pl_s = SB'(r_pdue >> (SB * i));
            end
        end
        plist = {pl_w, pl_s};
    end

    assign lvl_digit = SB'(r_tick >> (SB * r_lvl));

    assign add_bad = (r_periodic && r_period_ms < 32'(TICK_MS))
                   || ((r_dl >> SPAN_BITS) != 32'd0)
                   || (r_periodic && ((r_iv >> SPAN_BITS) != 32'd0))
                   || (r_held >= KW'(POOL_SIZE));

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_list;
        slot_wdata = '{first: htw_pkg::NIL, tail: htw_pkg::NIL};
        slot_raddr = (r_state == S_PL0) ? plist : r_list;
        link_we    = 1'b0;
        link_waddr = r_pidx;
        link_wdata = htw_pkg::NIL;
        ent_we     = 1'b0;
        ent_waddr  = ci;
        ent_wdata  = r_ent_q;
        ent_raddr  = (r_state == S_CRD) ? r_idx : ci;
        o_div_req  = '{start: 1'b0, num: i_delay_ms};
        o_push     = '{push: 1'b0, id: r_ent_q.ident};
        case (r_state)
            S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr;
            end
            S_IDLE: begin
                o_div_req.start = i_start && (i_op == htw_pkg::OP_ADD);
            end
            S_DIV: begin
                o_div_req.start = i_div_rsp.done && !r_divsel;
                o_div_req.num   = r_period_ms;
            end
            S_AWRITE: begin
                ent_we    = 1'b1;
                ent_waddr = r_idx;
                ent_wdata = '{due: r_tick + r_dl,
                              period: r_periodic ? r_iv : 32'd0,
                              ident: r_next_id + 32'd1,
                              repeat_en: r_periodic};
            end
            S_WHEAD2: begin
                slot_we = 1'b1;
            end
            S_WDATA: begin
                if (!r_canc[ci] && r_fire) begin
                    o_push.push = 1'b1;
                    if (r_ent_q.repeat_en) begin
                        ent_we        = 1'b1;
                        ent_wdata.due = r_tick + r_ent_q.period;
                    end
                end
            end
            S_PL0: begin
                link_we = 1'b1;
            end
            S_PL1: begin
                slot_we    = 1'b1;
                slot_waddr = r_plist;
                if (slot_empty) begin
                    slot_wdata = '{first: 7'(r_pidx), tail: 7'(r_pidx)};
                end else begin
                    slot_wdata = '{first: r_slot_q.first, tail: 7'(r_pidx)};
                    link_we    = 1'b1;
                    link_waddr = r_slot_q.tail[IW-1:0];
                    link_wdata = 7'(r_pidx);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (ent_we) begin
            entry_mem[ent_waddr] <= ent_wdata;
        end
        r_slot_q <= slot_mem[slot_raddr];
        r_link_q <= link_mem[ci];
        r_ent_q  <= entry_mem[ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_tick    <= '0;
            r_next_id <= '0;
            r_held    <= '0;
            r_used    <= '0;
            r_canc    <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + LW'(1);
                    if (r_clr == LW'(LIST_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_periodic  <= i_periodic;
                        r_period_ms <= i_period_ms;
                        r_cid       <= i_cancel_id;
                        r_idx       <= '0;
                        case (i_op)
                            htw_pkg::OP_ADD: begin
                                r_divsel <= 1'b0;
                                r_state  <= S_DIV;
                            end
                            htw_pkg::OP_CANCEL: begin
                                r_state <= S_CRD;
                            end
                            htw_pkg::OP_CANCEL_ALL: begin
                                r_canc  <= r_canc | r_used;
                                r_kind  <= htw_pkg::KIND_CANCEL_ALL;
                                r_id    <= '0;
                                r_ok    <= 1'b1;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_lvl       <= LVW'(1);
                                r_prev_zero <= (r_tick[SB-1:0] == '0);
                                r_state     <= S_TLVL;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        if (!r_divsel) begin
                            r_dl     <= i_div_rsp.quot;
                            r_divsel <= 1'b1;
                        end else begin
                            r_iv    <= i_div_rsp.quot;
                            r_state <= S_ACHK;
                        end
                    end
                end
                S_ACHK: begin
                    if (add_bad) begin
                        r_kind  <= htw_pkg::KIND_ADD;
                        r_id    <= '0;
                        r_ok    <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_AFREE;
                    end
                end
                S_AFREE: begin
                    if (!r_used[r_idx]) begin
                        r_state <= S_AWRITE;
                    end else if (r_idx == IW'(POOL_SIZE - 1)) begin
                        r_kind  <= htw_pkg::KIND_ADD;
                        r_id    <= '0;
                        r_ok    <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_AWRITE: begin
                    r_next_id     <= r_next_id + 32'd1;
                    r_used[r_idx] <= 1'b1;
                    r_canc[r_idx] <= 1'b0;
                    r_held        <= r_held + KW'(1);
                    r_kind        <= htw_pkg::KIND_ADD;
                    r_id          <= r_next_id + 32'd1;
                    r_ok          <= 1'b1;
                    r_pidx        <= r_idx;
                    r_pdue        <= r_tick + r_dl;
                    r_ret         <= S_DONE;
                    r_state       <= S_PL0;
                end
                S_CRD: begin
                    r_state <= S_CCK;
                end
                S_CCK: begin
                    r_kind <= htw_pkg::KIND_CANCEL;
                    r_id   <= r_cid;
                    if (r_used[r_idx] && !r_canc[r_idx] && r_ent_q.ident == r_cid) begin
                        r_canc[r_idx] <= 1'b1;
                        r_ok          <= 1'b1;
                        r_state       <= S_DONE;
                    end else if (r_idx == IW'(POOL_SIZE - 1)) begin
                        r_ok    <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_CRD;
                    end
                end
                S_TLVL: begin
                    // cascade upper wheels while the wheels below wrap
                    if (r_lvl < LVW'(WC) && r_prev_zero) begin
                        r_list      <= {WB'(r_lvl), lvl_digit};
                        r_prev_zero <= (lvl_digit == '0);
                        r_lvl       <= r_lvl + LVW'(1);
                        r_fire      <= 1'b0;
                    end else begin
                        r_list <= {WB'(0), r_tick[SB-1:0]};
                        r_fire <= 1'b1;
                    end
                    r_state <= S_WHEAD;
                end
                S_WHEAD: begin
                    r_state <= S_WHEAD2;
                end
                S_WHEAD2: begin
                    r_cur   <= r_slot_q.first;
                    r_n     <= '0;
                    r_state <= S_WLOOP;
                end
                S_WLOOP: begin
                    if (r_cur >= 7'(POOL_SIZE) || r_n == CW'(POOL_SIZE)) begin
                        r_state <= r_fire ? S_TEND : S_TLVL;
                    end else begin
                        r_state <= S_WDATA;
                    end
                end
                S_WDATA: begin
                    r_cur  <= r_link_q;
                    r_n    <= r_n + CW'(1);
                    r_pidx <= ci;
                    r_ret  <= S_WLOOP;
                    if (r_canc[ci] || (r_fire && !r_ent_q.repeat_en)) begin
                        r_used[ci] <= 1'b0;
                        if (r_held != '0) begin
                            r_held <= r_held - KW'(1);
                        end
                        r_state <= S_WLOOP;
                    end else begin
                        r_pdue  <= r_fire ? r_tick + r_ent_q.period : r_ent_q.due;
                        r_state <= S_PL0;
                    end
                end
                S_PL0: begin
                    r_plist <= plist;
                    r_state <= S_PL1;
                end
                S_PL1: begin
                    r_state <= r_ret;
                end
                S_TEND: begin
                    r_tick  <= r_tick + 32'd1;
                    r_kind  <= htw_pkg::KIND_TICK_DONE;
                    r_id    <= '0;
                    r_ok    <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_drain = '{req: (r_state == S_DONE), kind: r_kind, id: r_id,
                       ok: r_ok, held: r_held};
    assign o_busy  = (r_state != S_IDLE);

endmodule

// File: sim/htw_expiry_checker.sv
// Result checker for the hierarchical timer wheel: predicts every result beat
// from the accepted commands and compares it with the block's output.
// Depends on htw_pkg.
`timescale 1ns / 1ps

module htw_expiry_checker
    import htw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_op,
    input  logic               i_periodic,
    input  logic [31:0]        i_period_ms,
    input  logic [31:0]        i_delay_ms,
    input  logic [31:0]        i_cancel_id,
    input  logic               o_valid,
    input  logic [2:0]         o_kind,
    input  logic [31:0]        o_timer_id,
    input  logic               o_ok,
    input  logic [6:0]         o_live_count,
    input  logic               o_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int SB    = SLOT_BITS_DEF;
    localparam int WC    = WHEEL_COUNT_DEF;
    localparam int PS    = POOL_SIZE_DEF;
    localparam int TMS   = TICK_MS_DEF;
    localparam int NL    = WC * (1 << SB);
    localparam longint SPAN = longint'(1) << (SB * WC);

    typedef struct {
        t_kind       kind;
        logic [31:0] id;
        logic        ok;
        logic [6:0]  live;
        logic        last;
    } htw_beat_t;

    logic [6:0]  head_q [NL];
    logic [6:0]  tail_q [NL];
    logic [6:0]  link_q [PS];
    logic [31:0] due_q [PS];
    logic [31:0] period_q [PS];
    logic [31:0] ident_q [PS];
    bit          repeat_q [PS];
    bit          dropped_q [PS];
    bit          used_q [PS];
    logic [31:0] now_tick;
    logic [31:0] last_id;
    int          held;

    logic [31:0] fired_ids[$];
    htw_beat_t   due_beats[$];
    int          mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = due_beats.size();

    // Put an entry on the lowest wheel whose range covers its remaining ticks.
    task automatic place_entry(input int idx);
        logic [31:0] left;
        int w;
        int s;
        int lst;
        left = due_q[idx] - now_tick;
        w = 0;
        s = 0;
        for (int i = WC - 1; i >= 0; i--) begin
            if (longint'(left) < (longint'(1) << (SB * (i + 1)))) begin
                w = i;
                s = int'((due_q[idx] >> (SB * i)) & ((1 << SB) - 1));
            end
        end
        lst = w * (1 << SB) + s;
        link_q[idx] = NIL;
        if (tail_q[lst] >= PS) head_q[lst] = 7'(idx);
        else link_q[tail_q[lst]] = 7'(idx);
        tail_q[lst] = 7'(idx);
    endtask

    task automatic free_entry(input int idx);
        used_q[idx] = 1'b0;
        if (held > 0) held--;
    endtask

    // Detach a slot list and walk it: expire on wheel 0, else cascade down.
    task automatic walk_slot(input int lst, input bit expire);
        int cur;
        int nxt;
        int n;
        cur = head_q[lst];
        head_q[lst] = NIL;
        tail_q[lst] = NIL;
        n = 0;
        while (cur < PS && n < PS) begin
            nxt = link_q[cur];
            if (dropped_q[cur]) begin
                free_entry(cur);
            end else if (!expire) begin
                place_entry(cur);
            end else begin
                if (fired_ids.size() < PS) fired_ids.push_back(ident_q[cur]);
                if (repeat_q[cur]) begin
                    due_q[cur] = now_tick + period_q[cur];
                    place_entry(cur);
                end else begin
                    free_entry(cur);
                end
            end
            cur = nxt;
            n++;
        end
    endtask

    task automatic predict_command(input t_op op, input logic per, input logic [31:0] pms,
                                   input logic [31:0] dms, input logic [31:0] cid);
        htw_beat_t   b;
        logic [31:0] iv;
        logic [31:0] dl;
        bit          bad;
        int          idx;
        int          cur;
        int          nx;
        htw_beat_t   outs[$];
        outs = {};
        fired_ids = {};
        b.ok = 1'b1;
        b.id = '0;
        case (op)
            OP_ADD: begin
                iv  = pms / TMS;
                dl  = dms / TMS;
                bad = (per && pms < TMS) || longint'(dl) >= SPAN ||
                      (per && longint'(iv) >= SPAN) || held >= PS;
                idx = 0;
                while (idx < PS && used_q[idx]) idx++;
                b.kind = KIND_ADD;
                if (bad || idx >= PS) begin
                    b.ok = 1'b0;
                end else begin
                    last_id++;
                    used_q[idx]    = 1'b1;
                    ident_q[idx]   = last_id;
                    repeat_q[idx]  = per;
                    dropped_q[idx] = 1'b0;
                    due_q[idx]     = now_tick + dl;
                    period_q[idx]  = per ? iv : '0;
                    place_entry(idx);
                    held++;
                    b.id = last_id;
                end
                outs.push_back(b);
            end
            OP_CANCEL: begin
                b.kind = KIND_CANCEL;
                b.id   = cid;
                b.ok   = 1'b0;
                for (int i = 0; i < PS; i++) begin
                    if (!b.ok && used_q[i] && !dropped_q[i] && ident_q[i] == cid) begin
                        dropped_q[i] = 1'b1;
                        b.ok = 1'b1;
                    end
                end
                outs.push_back(b);
            end
            OP_CANCEL_ALL: begin
                for (int i = 0; i < PS; i++) if (used_q[i]) dropped_q[i] = 1'b1;
                b.kind = KIND_CANCEL_ALL;
                outs.push_back(b);
            end
            default: begin
                // Cascade higher wheels while the lower ones wrap, then expire.
                cur = int'(now_tick & ((1 << SB) - 1));
                nx  = cur;
                for (int i = 0; i + 1 < WC && nx == 0; i++) begin
                    nx = int'((now_tick >> ((i + 1) * SB)) & ((1 << SB) - 1));
                    walk_slot((i + 1) * (1 << SB) + nx, 1'b0);
                end
                walk_slot(cur, 1'b1);
                foreach (fired_ids[i]) begin
                    b.kind = KIND_FIRED;
                    b.id   = fired_ids[i];
                    outs.push_back(b);
                end
                if (outs.size() == 0) begin
                    b.kind = KIND_TICK_DONE;
                    outs.push_back(b);
                end
                now_tick++;
            end
        endcase
        foreach (outs[i]) begin
            outs[i].live = 7'(held);
            outs[i].last = (i == outs.size() - 1);
            due_beats.push_back(outs[i]);
        end
    endtask

    always @(posedge i_clk) begin
        htw_beat_t e;
        if (!i_rst_n) begin
            for (int i = 0; i < NL; i++) begin
                head_q[i] = NIL;
                tail_q[i] = NIL;
            end
            for (int i = 0; i < PS; i++) begin
                used_q[i]    = 1'b0;
                dropped_q[i] = 1'b0;
            end
            now_tick   = '0;
            last_id    = '0;
            held       = 0;
            mismatches = 0;
            due_beats  = {};
        end else begin
            // Check the beat on the output first, then predict a new command.
            if (o_valid) begin
                if (due_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat kind=%0d id=%0d",
                                 $realtime, o_kind, o_timer_id);
                end else begin
                    e = due_beats.pop_front();
                    if (o_kind !== e.kind || o_timer_id !== e.id || o_ok !== e.ok ||
                        o_live_count !== e.live || o_last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch exp kind=%0d id=%0d ok=%0b live=%0d last=%0b act kind=%0d id=%0d ok=%0b live=%0d last=%0b",
                                     $realtime, e.kind, e.id, e.ok, e.live, e.last,
                                     o_kind, o_timer_id, o_ok, o_live_count, o_last);
                    end
                end
            end
            if (start && !busy)
                predict_command(t_op'(i_op), i_periodic, i_period_ms, i_delay_ms, i_cancel_id);
        end
    end

endmodule

// File: sim/tb_hierarchical_timer_wheel_core.sv
// Testbench top for hierarchical_timer_wheel_core: drives directed and random
// commands in bursts; htw_expiry_checker predicts and compares the results.
// Depends on htw_pkg, the core RTL and htw_expiry_checker.
`timescale 1ns / 1ps

module tb_hierarchical_timer_wheel_core;
    import htw_pkg::*;

    localparam int TMS = TICK_MS_DEF;
    // Last delay in ms that still fits the wheel span (2^24 ticks).
    localparam logic [31:0] MAX_DELAY_MS = 32'd838860799;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_op         cmd_op;
    logic        cmd_periodic;
    logic [31:0] cmd_period_ms;
    logic [31:0] cmd_delay_ms;
    logic [31:0] cmd_cancel_id;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [31:0] o_timer_id;
    logic        o_ok;
    logic [6:0]  o_live_count;
    logic        o_last;
    int          fail_count;
    int          pending;
    int          burst_left;

    hierarchical_timer_wheel_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (cmd_op),
        .i_periodic   (cmd_periodic),
        .i_period_ms  (cmd_period_ms),
        .i_delay_ms   (cmd_delay_ms),
        .i_cancel_id  (cmd_cancel_id),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_timer_id   (o_timer_id),
        .o_ok         (o_ok),
        .o_live_count (o_live_count),
        .o_last       (o_last)
    );

    htw_expiry_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (cmd_op),
        .i_periodic   (cmd_periodic),
        .i_period_ms  (cmd_period_ms),
        .i_delay_ms   (cmd_delay_ms),
        .i_cancel_id  (cmd_cancel_id),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_timer_id   (o_timer_id),
        .o_ok         (o_ok),
        .o_live_count (o_live_count),
        .o_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Send one command beat. Between bursts, drop start for a random gap;
    // within a burst, hold start high so beats go back to back.
    task automatic send_cmd(input t_op op, input logic per, input logic [31:0] pms,
                            input logic [31:0] dms, input logic [31:0] cid);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        start         <= 1'b1;
        cmd_op        <= op;
        cmd_periodic  <= per;
        cmd_period_ms <= pms;
        cmd_delay_ms  <= dms;
        cmd_cancel_id <= cid;
        do @(posedge i_clk); while (busy);
        burst_left--;
    endtask

    // Hold off until every predicted result has come out.
    task automatic drain_results();
        start <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_tick();
        send_cmd(OP_TICK, 1'($urandom), $urandom, $urandom, $urandom);
    endtask

    task automatic send_random();
        int          pick;
        logic        per;
        logic [31:0] pms;
        logic [31:0] dms;
        logic [31:0] cid;
        pick = $urandom_range(0, 99);
        per  = 1'($urandom);
        pms  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3000);
        dms  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5000);
        cid  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 250);
        if (pick < 55) send_tick();
        else if (pick < 85) send_cmd(OP_ADD, per, pms, dms, $urandom);
        else if (pick < 97) send_cmd(OP_CANCEL, per, pms, dms, cid);
        else send_cmd(OP_CANCEL_ALL, per, pms, dms, cid);
    endtask

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        cmd_op        <= OP_ADD;
        cmd_periodic  <= 1'b0;
        cmd_period_ms <= '0;
        cmd_delay_ms  <= '0;
        cmd_cancel_id <= '0;
        burst_left    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: boundaries of the add checks, cancels and a few ticks.
        send_cmd(OP_ADD, 1'b0, 32'd0, 32'd0, 32'd0);
        send_cmd(OP_ADD, 1'b1, TMS - 1, 32'd100, 32'd0);
        send_cmd(OP_ADD, 1'b1, TMS, 32'd100, 32'd0);
        send_cmd(OP_ADD, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_cmd(OP_ADD, 1'b0, 32'd0, MAX_DELAY_MS + 1, 32'd0);
        send_cmd(OP_ADD, 1'b0, 32'hFFFF_FFFF, MAX_DELAY_MS, 32'hFFFF_FFFF);
        send_cmd(OP_ADD, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_cmd(OP_ADD, 1'b1, MAX_DELAY_MS, 32'd3200, 32'd0);
        send_cmd(OP_ADD, 1'b0, 32'd0, 32'd149, 32'd0);
        send_cmd(OP_CANCEL, 1'b0, 32'd0, 32'd0, 32'd5);
        send_cmd(OP_CANCEL, 1'b0, 32'd0, 32'd0, 32'd5);
        send_cmd(OP_CANCEL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(OP_CANCEL, 1'b0, 32'd0, 32'd0, 32'd0);
        repeat (4) send_tick();
        send_cmd(OP_CANCEL_ALL, 1'b0, 32'd0, 32'd0, 32'd0);
        repeat (3) send_tick();
        drain_results();

        // Fill the pool with near timers, overflow it, let them fire, then cancel all.
        repeat (66) send_cmd(OP_ADD, 1'($urandom), $urandom_range(TMS, 400),
                             $urandom_range(0, 199), $urandom);
        repeat (5) send_tick();
        send_cmd(OP_CANCEL_ALL, 1'b0, 32'd0, 32'd0, 32'd0);
        repeat (10) send_tick();
        drain_results();

        // Short random mix, weighted toward ticks.
        repeat (8) send_random();

        drain_results();
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
